@@ rtl/cpr_pkg.sv @@
// Shared types and codes for the clock page replacement unit.
// Used by the top level, the victim picker and the port checker.
// No dependencies.
`default_nettype none

package cpr_pkg;

    localparam logic [1:0] OP_REFERENCE = 2'd0;
    localparam logic [1:0] OP_LOAD      = 2'd1;
    localparam logic [1:0] OP_VICTIM    = 2'd2;
    localparam logic [1:0] OP_RELEASE   = 2'd3;

    localparam logic STATUS_OK    = 1'b0;
    localparam logic STATUS_EMPTY = 1'b1;

    localparam logic POLICY_CLOCK    = 1'b0;
    localparam logic POLICY_ENHANCED = 1'b1;

    // One word of the frame memory.
    typedef struct packed {
        logic present;
        logic used;
        logic modified;
    } entry_t;

    // Verdict on one frame passed by the hand.
    typedef struct packed {
        logic hit;
        logic clear_used;
    } pick_t;

endpackage

`default_nettype wire

@@ rtl/cpr_victim_pick.sv @@
// Per-frame victim decision for plain and enhanced clock sweeps.
// Depends on cpr_pkg for entry_t and pick_t.
`default_nettype none

module cpr_victim_pick (
    input  wire logic           policy_mode,
    input  wire logic           odd_sweep,
    input  wire cpr_pkg::entry_t entry,
    output cpr_pkg::pick_t      pick
);

    always_comb
    begin
        pick = '0;
        if (entry.present)
        begin
            if (policy_mode == cpr_pkg::POLICY_CLOCK)
            begin
                pick.hit        = !entry.used;
                pick.clear_used = entry.used;
            end
            else if (!odd_sweep)
            begin
                // First and third sweeps look for unused clean frames and change nothing.
                pick.hit        = !entry.used && !entry.modified;
                pick.clear_used = 1'b0;
            end
            else
            begin
                // Second and fourth sweeps take unused dirty frames and age the rest.
                pick.hit        = !entry.used && entry.modified;
                pick.clear_used = !pick.hit && entry.used;
            end
        end
    end

endmodule

`default_nettype wire

@@ rtl/clock_page_replacement_unit.sv @@
// Top level of the clock page replacement unit: frame memory, sequencer, output register.
// Depends on cpr_pkg and cpr_victim_pick.
//
// Usage:
// Input items (opcode, frame_index, is_write) arrive on a valid/ready channel and every
// item produces exactly one result item (status, victim_frame, victim_dirty) on a
// valid/ready output channel. Frame bits live in a single-port-read, single-port-write
// synchronous memory with a registered read port, one word per frame.
// A reference, load or release issues the memory read at the accept edge; in ST_RMW it
// then writes the modified word back and loads the result register once it is free.
// A victim request reads one frame per cycle starting at the clock hand and stops at
// the first hit, where it waits until the result register is free; with no present
// frame it finishes through ST_RMW with status 1.
// One item is in flight at a time; in_ready is high only while the sequencer is idle.
// The result register lets the next item be accepted while a result waits; if the
// receiver still holds a result when the next one is ready, the sequencer waits.
// After reset a clearing pass writes every memory word to zero with in_ready low.
// The policy register takes cfg_wdata at any edge with cfg_we high; it should only be
// changed while no item is in flight.
`default_nettype none

module clock_page_replacement_unit #(
    parameter int FRAME_COUNT = 64
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       cfg_we,
    input  wire logic       cfg_wdata,
    input  wire logic       in_valid,
    output      logic       in_ready,
    input  wire logic [1:0] opcode,
    input  wire logic [5:0] frame_index,
    input  wire logic       is_write,
    output      logic       out_valid,
    input  wire logic       out_ready,
    output      logic       status,
    output      logic [5:0] victim_frame,
    output      logic       victim_dirty
);

    localparam int FW = $clog2(FRAME_COUNT);
    localparam int CW = $clog2(FRAME_COUNT + 1);
    localparam logic [FW-1:0] LAST_FRAME = FW'(FRAME_COUNT - 1);

    typedef enum logic [3:0] {
        ST_CLEAR = 4'b0001,
        ST_IDLE  = 4'b0010,
        ST_RMW   = 4'b0100,
        ST_SCAN  = 4'b1000
    } state_t;

    state_t            state_reg, state_next;
    logic              policy_reg;
    logic [FW-1:0]     hand_reg, hand_next;
    logic [FW-1:0]     cur_reg, cur_next;
    logic [FW-1:0]     sweep_cnt_reg, sweep_cnt_next;
    logic              phase_reg, phase_next;
    logic [1:0]        op_reg, op_next;
    logic              wr_flag_reg, wr_flag_next;
    logic              in_range_reg, in_range_next;
    logic [CW-1:0]     count_reg, count_next;
    logic              out_valid_reg;
    logic              status_reg;
    logic [5:0]        victim_frame_reg;
    logic              victim_dirty_reg;

    cpr_pkg::entry_t   mem [FRAME_COUNT];
    cpr_pkg::entry_t   rd_data_reg;
    logic              rd_en;
    logic [FW-1:0]     rd_addr;
    logic              wr_en;
    logic [FW-1:0]     wr_addr;
    cpr_pkg::entry_t   wr_data;

    logic              out_load;
    logic              out_free;
    logic              res_status;
    logic [5:0]        res_frame;
    logic              res_dirty;
    logic [FW-1:0]     nxt_frame;
    cpr_pkg::pick_t    pick;

    cpr_victim_pick u_pick (
        .policy_mode (policy_reg),
        .odd_sweep   (phase_reg),
        .entry       (rd_data_reg),
        .pick        (pick)
    );

    assign nxt_frame = (cur_reg == LAST_FRAME) ? '0 : cur_reg + FW'(1);
    assign out_free  = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next     = state_reg;
        hand_next      = hand_reg;
        cur_next       = cur_reg;
        sweep_cnt_next = sweep_cnt_reg;
        phase_next     = phase_reg;
        op_next        = op_reg;
        wr_flag_next   = wr_flag_reg;
        in_range_next  = in_range_reg;
        count_next     = count_reg;
        rd_en          = 1'b0;
        rd_addr        = nxt_frame;
        wr_en          = 1'b0;
        wr_addr        = cur_reg;
        wr_data        = '0;
        out_load       = 1'b0;
        res_status     = cpr_pkg::STATUS_OK;
        res_frame      = '0;
        res_dirty      = 1'b0;

        case (state_reg)
            ST_CLEAR:
            begin
                wr_en = 1'b1;
                if (cur_reg == LAST_FRAME)
                begin
                    cur_next   = '0;
                    state_next = ST_IDLE;
                end
                else
                begin
                    cur_next = nxt_frame;
                end
            end

            ST_IDLE:
            begin
                if (in_valid)
                begin
                    op_next       = opcode;
                    wr_flag_next  = is_write;
                    in_range_next = (32'(frame_index) < FRAME_COUNT);
                    rd_en         = 1'b1;
                    if (opcode == cpr_pkg::OP_VICTIM && count_reg != '0)
                    begin
                        rd_addr        = hand_reg;
                        cur_next       = hand_reg;
                        sweep_cnt_next = '0;
                        phase_next     = 1'b0;
                        state_next     = ST_SCAN;
                    end
                    else
                    begin
                        rd_addr    = FW'(frame_index);
                        cur_next   = FW'(frame_index);
                        state_next = ST_RMW;
                    end
                end
            end

            ST_RMW:
            begin
                if (out_free)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                    if (op_reg == cpr_pkg::OP_VICTIM)
                    begin
                        res_status = cpr_pkg::STATUS_EMPTY;
                    end
                    else if (in_range_reg)
                    begin
                        wr_en = 1'b1;
                        case (op_reg)
                            cpr_pkg::OP_REFERENCE:
                            begin
                                wr_data.present  = rd_data_reg.present;
                                wr_data.used     = 1'b1;
                                wr_data.modified = rd_data_reg.modified || wr_flag_reg;
                            end
                            cpr_pkg::OP_LOAD:
                            begin
                                wr_data.present  = 1'b1;
                                wr_data.used     = 1'b1;
                                wr_data.modified = 1'b0;
                                if (!rd_data_reg.present)
                                begin
                                    count_next = count_reg + CW'(1);
                                end
                            end
                            default:
                            begin
                                wr_data = '0;
                                if (rd_data_reg.present)
                                begin
                                    count_next = count_reg - CW'(1);
                                end
                            end
                        endcase
                    end
                end
            end

            ST_SCAN:
            begin
                if (pick.hit)
                begin
                    // Hold the frame under the hand until the result register frees up.
                    if (out_free)
                    begin
                        wr_en      = 1'b1;
                        out_load   = 1'b1;
                        res_frame  = 6'(cur_reg);
                        res_dirty  = rd_data_reg.modified;
                        hand_next  = nxt_frame;
                        count_next = count_reg - CW'(1);
                        state_next = ST_IDLE;
                    end
                end
                else
                begin
                    // The next frame is read while this one's used bit is cleared where the picker asks.
                    rd_en            = 1'b1;
                    wr_en            = pick.clear_used;
                    wr_data.present  = 1'b1;
                    wr_data.used     = 1'b0;
                    wr_data.modified = rd_data_reg.modified;
                    cur_next         = nxt_frame;
                    hand_next        = nxt_frame;
                    if (sweep_cnt_reg == LAST_FRAME)
                    begin
                        sweep_cnt_next = '0;
                        phase_next     = !phase_reg;
                    end
                    else
                    begin
                        sweep_cnt_next = sweep_cnt_reg + FW'(1);
                    end
                end
            end

            default:
            begin
                state_next = ST_CLEAR;
                cur_next   = '0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            policy_reg    <= cpr_pkg::POLICY_CLOCK;
            hand_reg      <= '0;
            cur_reg       <= '0;
            sweep_cnt_reg <= '0;
            phase_reg     <= 1'b0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            hand_reg      <= hand_next;
            cur_reg       <= cur_next;
            sweep_cnt_reg <= sweep_cnt_next;
            phase_reg     <= phase_next;
            count_reg     <= count_next;
            if (cfg_we)
            begin
                policy_reg <= cfg_wdata;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        wr_flag_reg  <= wr_flag_next;
        in_range_reg <= in_range_next;
        if (out_load)
        begin
            status_reg       <= res_status;
            victim_frame_reg <= res_frame;
            victim_dirty_reg <= res_dirty;
        end
    end

    assign out_valid    = out_valid_reg;
    assign status       = status_reg;
    assign victim_frame = victim_frame_reg;
    assign victim_dirty = victim_dirty_reg;

endmodule

`default_nettype wire

@@ rtl/cpr_checker.sv @@
// Port-level checks for the clock page replacement unit, bound to the top level.
// Depends on cpr_pkg for the status codes.
`default_nettype none

module cpr_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       in_valid,
    input wire logic       in_ready,
    input wire logic       out_valid,
    input wire logic       out_ready,
    input wire logic       status,
    input wire logic [5:0] victim_frame,
    input wire logic       victim_dirty
);

    // A waiting result item must not change until it is taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status) &&
            $stable(victim_frame) && $stable(victim_dirty))
    else $error("result item changed while stalled");

    // A failed victim request carries no frame and no dirty flag.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == cpr_pkg::STATUS_EMPTY |-> victim_frame == '0 && !victim_dirty)
    else $error("empty status with nonzero victim fields");

    // Only one item is worked on at a time.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
    else $error("second item accepted while one is in progress");

endmodule

bind clock_page_replacement_unit cpr_checker u_cpr_checker (.*);

`default_nettype wire
